// ===== rtl/json_token_lexer_defines.svh =====
// Assertion macros shared by the JSON token lexer RTL.
`ifndef JSON_TOKEN_LEXER_DEFINES_SVH
`define JSON_TOKEN_LEXER_DEFINES_SVH

// Checks in the same cycle, under clk and arst_n of the enclosing module.
`define JTL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks in the next cycle, under clk and arst_n of the enclosing module.
`define JTL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jtl_pkg.sv =====
// Types, codes and helper functions of the JSON token lexer.
package jtl_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LINE_BITS   = 16;
	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);

	localparam logic [3:0] KIND_LBRACKET = 4'd0;
	localparam logic [3:0] KIND_RBRACKET = 4'd1;
	localparam logic [3:0] KIND_LBRACE   = 4'd2;
	localparam logic [3:0] KIND_RBRACE   = 4'd3;
	localparam logic [3:0] KIND_COLON    = 4'd4;
	localparam logic [3:0] KIND_COMMA    = 4'd5;
	localparam logic [3:0] KIND_TRUE     = 4'd6;
	localparam logic [3:0] KIND_STRING   = 4'd9;
	localparam logic [3:0] KIND_INT      = 4'd10;
	localparam logic [3:0] KIND_DEC      = 4'd11;
	localparam logic [3:0] KIND_EOF      = 4'd12;
	localparam logic [3:0] KIND_ERR      = 4'd13;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_LITERAL = 3'd1;
	localparam logic [2:0] ERR_STRING  = 3'd2;
	localparam logic [2:0] ERR_NUMBER  = 3'd3;
	localparam logic [2:0] ERR_OVERFLOW = 3'd4;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	localparam logic [32:0] ACC_LIMIT    = 33'h080000000;
	localparam logic [32:0] ACC_OVF_MARK = 33'h080000001;
	localparam logic [32:0] ACC_POS_MAX  = 33'h07FFFFFFF;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_LITERAL,
		MODE_STRING,
		MODE_NUMBER
	} lex_mode_t;

	typedef enum logic [2:0] {
		IC_SKIP,
		IC_PUNCT,
		IC_LITERAL,
		IC_STRING,
		IC_NUMBER,
		IC_BAD
	} idle_cls_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} jtl_in_t;

	typedef struct packed {
		logic [3:0]             token_kind;
		logic [2:0]             error_code;
		logic signed [31:0]     token_int;
		logic [OFFSET_BITS-1:0] token_offset;
		logic [OFFSET_BITS-1:0] token_length;
		logic [LINE_BITS-1:0]   token_line;
		logic [LINE_BITS-1:0]   token_column;
		logic                   last_of_run;
	} jtl_out_t;

	typedef struct packed {
		logic ovf;
		logic stop;
		logic dot;
		logic digit;
		logic sign;
	} num_flags_t;

	typedef struct packed {
		num_flags_t  flags;
		logic [32:0] acc;
	} num_st_t;

	function automatic logic in_num_set(logic [7:0] c);
		return (c == CH_MINUS) || (c == CH_DOT) || ((c >= CH_ZERO) && (c <= CH_NINE));
	endfunction

	function automatic logic [2:0] lit_len(logic [1:0] k);
		return (k == LIT_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [7:0] lit_char(logic [1:0] k, logic [2:0] p);
		logic [7:0] ch;
		ch = 8'h00;
		case (k)
			LIT_TRUE: begin
				case (p)
					3'd0: ch = "t";
					3'd1: ch = "r";
					3'd2: ch = "u";
					3'd3: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			LIT_FALSE: begin
				case (p)
					3'd0: ch = "f";
					3'd1: ch = "a";
					3'd2: ch = "l";
					3'd3: ch = "s";
					3'd4: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			default: begin
				case (p)
					3'd0: ch = "n";
					3'd1: ch = "u";
					3'd2: ch = "l";
					3'd3: ch = "l";
					default: ch = 8'h00;
				endcase
			end
		endcase
		return ch;
	endfunction

	function automatic num_st_t num_feed(num_st_t st, logic [7:0] c, logic first);
		num_st_t     r;
		logic [35:0] prod;
		r = st;
		prod = ({3'b000, st.acc} << 3) + ({3'b000, st.acc} << 1) + 36'(c[3:0]);
		if (st.flags.stop) begin
			if (c == CH_DOT) r.flags.dot = 1'b1;
		end else if (c == CH_MINUS) begin
			if (first) r.flags.sign = 1'b1;
			else r.flags.stop = 1'b1;
		end else if (c == CH_DOT) begin
			if (st.flags.dot) r.flags.stop = 1'b1;
			else r.flags.dot = 1'b1;
		end else begin
			r.flags.digit = 1'b1;
			if (!(st.flags.dot || st.flags.ovf)) begin
				if (prod > 36'(ACC_LIMIT)) begin
					r.flags.ovf = 1'b1;
					r.acc = ACC_OVF_MARK;
				end else begin
					r.acc = prod[32:0];
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/json_token_lexer.sv =====
// JSON token lexer: one text byte or end marker per request, up to two tokens out.
// A request's tokens are registered in the result queue, behind any older tokens.
// Throughput: one request per cycle; a four-entry result queue takes up to two tokens
// per request, and in_ready drops while more than two tokens wait in it.
// Reset clears the lexer state and the result queue at once; no clearing pass.
module json_token_lexer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  jtl_pkg::jtl_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output jtl_pkg::jtl_out_t out_data
);
	import jtl_pkg::*;

	`include "json_token_lexer_defines.svh"

	lex_mode_t              mode_q, mode_d;
	logic [1:0]             lit_k_q, lit_k_d;
	logic [2:0]             lit_pos_q, lit_pos_d;
	logic [OFFSET_BITS-1:0] byte_pos_q, byte_pos_d;
	logic [OFFSET_BITS-1:0] start_pos_q, start_pos_d;
	logic [LINE_BITS-1:0]   cur_line_q, cur_line_d;
	logic [LINE_BITS-1:0]   cur_col_q, cur_col_d;
	logic [LINE_BITS-1:0]   start_line_q, start_line_d;
	logic [LINE_BITS-1:0]   start_col_q, start_col_d;
	num_st_t                num_q, num_d;
	logic                   halted_q, halted_d;

	jtl_out_t               fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]       rd_ptr_q, wr_ptr_q, wr_ptr_nx;
	logic [PTR_W:0]         cnt_q;
	logic [1:0]             push_n;
	logic                   pop;

	logic                   fire;
	logic                   is_end;
	logic [7:0]             c;
	logic                   c_num;
	logic [OFFSET_BITS-1:0] diff;
	logic [OFFSET_BITS:0]   diff_inc;
	logic [OFFSET_BITS-1:0] diff_inc_sat;
	logic [OFFSET_BITS-1:0] str_len;
	logic                   lit_match;
	logic                   lit_done;
	idle_cls_t              idle_cls;
	logic [3:0]             idle_kind;
	logic [1:0]             idle_lit;
	logic                   fin_halt;
	jtl_out_t               fin_tok, eof_tok, idle_tok;
	jtl_out_t               res0, res1;
	logic [1:0]             res_cnt;

	function automatic jtl_out_t make_tok(logic [3:0] kind, logic [2:0] err,
		logic [31:0] val, logic [OFFSET_BITS-1:0] off, logic [OFFSET_BITS-1:0] len,
		logic [LINE_BITS-1:0] line, logic [LINE_BITS-1:0] col);
		jtl_out_t t;
		t.token_kind   = kind;
		t.error_code   = err;
		t.token_int    = val;
		t.token_offset = off;
		t.token_length = len;
		t.token_line   = line;
		t.token_column = col;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	assign fire     = in_valid && in_ready;
	assign in_ready = (cnt_q <= (PTR_W + 1)'(FIFO_DEPTH - 2));
	assign is_end   = in_data.opcode;
	assign c        = in_data.data_byte;
	assign c_num    = in_num_set(c);

	assign diff         = byte_pos_q - start_pos_q;
	assign diff_inc     = {1'b0, diff} + 1'b1;
	assign diff_inc_sat = diff_inc[OFFSET_BITS] ? '1 : diff_inc[OFFSET_BITS-1:0];
	assign str_len      = (diff == '0) ? '0 : diff - 1'b1;

	assign lit_match = (lit_pos_q < lit_len(lit_k_q)) && (c == lit_char(lit_k_q, lit_pos_q));
	assign lit_done  = (3'(lit_pos_q + 3'd1) == lit_len(lit_k_q));

	always_comb begin
		idle_cls  = IC_BAD;
		idle_kind = KIND_ERR;
		idle_lit  = LIT_TRUE;
		case (c)
			CH_SPACE, CH_NEWLINE: idle_cls = IC_SKIP;
			"[": begin
				idle_cls  = IC_PUNCT;
				idle_kind = KIND_LBRACKET;
			end
			"]": begin
				idle_cls  = IC_PUNCT;
				idle_kind = KIND_RBRACKET;
			end
			"{": begin
				idle_cls  = IC_PUNCT;
				idle_kind = KIND_LBRACE;
			end
			"}": begin
				idle_cls  = IC_PUNCT;
				idle_kind = KIND_RBRACE;
			end
			":": begin
				idle_cls  = IC_PUNCT;
				idle_kind = KIND_COLON;
			end
			",": begin
				idle_cls  = IC_PUNCT;
				idle_kind = KIND_COMMA;
			end
			"t": begin
				idle_cls = IC_LITERAL;
				idle_lit = LIT_TRUE;
			end
			"f": begin
				idle_cls = IC_LITERAL;
				idle_lit = LIT_FALSE;
			end
			"n": begin
				idle_cls = IC_LITERAL;
				idle_lit = LIT_NULL;
			end
			CH_QUOTE: idle_cls = IC_STRING;
			default: begin
				if (c_num) idle_cls = IC_NUMBER;
			end
		endcase
	end

	// Closing a number uses the flags as they stand before the current byte.
	always_comb begin
		fin_halt = 1'b0;
		if (!num_q.flags.digit) begin
			fin_halt = 1'b1;
			fin_tok  = make_tok(KIND_ERR, ERR_NUMBER, '0, start_pos_q, diff,
				start_line_q, start_col_q);
		end else if (num_q.flags.dot) begin
			fin_tok = make_tok(KIND_DEC, ERR_NONE, '0, start_pos_q, diff,
				start_line_q, start_col_q);
		end else if (num_q.flags.ovf || (!num_q.flags.sign && (num_q.acc > ACC_POS_MAX))) begin
			fin_halt = 1'b1;
			fin_tok  = make_tok(KIND_ERR, ERR_OVERFLOW, '0, start_pos_q, diff,
				start_line_q, start_col_q);
		end else begin
			fin_tok = make_tok(KIND_INT, ERR_NONE,
				num_q.flags.sign ? 32'(-num_q.acc[31:0]) : num_q.acc[31:0],
				start_pos_q, diff, start_line_q, start_col_q);
		end
	end

	assign eof_tok  = make_tok(KIND_EOF, ERR_NONE, '0, byte_pos_q, '0, cur_line_q, cur_col_q);
	assign idle_tok = make_tok((idle_cls == IC_PUNCT) ? idle_kind : KIND_ERR,
		(idle_cls == IC_PUNCT) ? ERR_NONE : ERR_NUMBER, '0, byte_pos_q,
		(idle_cls == IC_PUNCT) ? OFFSET_BITS'(1) : '0, cur_line_q, cur_col_q);

	always_comb begin
		res0    = eof_tok;
		res1    = eof_tok;
		res_cnt = 2'd0;
		if (!halted_q) begin
			if (is_end) begin
				case (mode_q)
					MODE_LITERAL: begin
						res0    = make_tok(KIND_ERR, ERR_LITERAL, '0, start_pos_q, diff,
							start_line_q, start_col_q);
						res_cnt = 2'd1;
					end
					MODE_STRING: begin
						res0    = make_tok(KIND_ERR, ERR_STRING, '0, start_pos_q, str_len,
							start_line_q, start_col_q);
						res_cnt = 2'd1;
					end
					MODE_NUMBER: begin
						res0    = fin_tok;
						res_cnt = fin_halt ? 2'd1 : 2'd2;
					end
					default: res_cnt = 2'd1;
				endcase
			end else begin
				case (mode_q)
					MODE_LITERAL: begin
						res_cnt = 2'd1;
						if (!lit_match) begin
							res0 = make_tok(KIND_ERR, ERR_LITERAL, '0, start_pos_q,
								diff_inc_sat, start_line_q, start_col_q);
						end else if (lit_done) begin
							res0 = make_tok(4'(KIND_TRUE + 4'(lit_k_q)), ERR_NONE, '0,
								start_pos_q, OFFSET_BITS'(lit_len(lit_k_q)),
								start_line_q, start_col_q);
						end else begin
							res_cnt = 2'd0;
						end
					end
					MODE_STRING: begin
						if (c == CH_QUOTE) begin
							res0    = make_tok(KIND_STRING, ERR_NONE, '0, start_pos_q, str_len,
								start_line_q, start_col_q);
							res_cnt = 2'd1;
						end
					end
					MODE_NUMBER: begin
						if (!c_num) begin
							res0    = fin_tok;
							res1    = idle_tok;
							res_cnt = (!fin_halt && (idle_cls == IC_PUNCT || idle_cls == IC_BAD))
								? 2'd2 : 2'd1;
						end
					end
					default: begin
						if (idle_cls == IC_PUNCT || idle_cls == IC_BAD) begin
							res0    = idle_tok;
							res_cnt = 2'd1;
						end
					end
				endcase
			end
		end
		res0.last_of_run = (res_cnt == 2'd1);
		res1.last_of_run = 1'b1;
	end

	always_comb begin
		mode_d       = mode_q;
		lit_k_d      = lit_k_q;
		lit_pos_d    = lit_pos_q;
		byte_pos_d   = byte_pos_q;
		start_pos_d  = start_pos_q;
		cur_line_d   = cur_line_q;
		cur_col_d    = cur_col_q;
		start_line_d = start_line_q;
		start_col_d  = start_col_q;
		num_d        = num_q;
		halted_d     = halted_q;
		if (fire) begin
			if (is_end) begin
				mode_d       = MODE_IDLE;
				lit_k_d      = '0;
				lit_pos_d    = '0;
				byte_pos_d   = '0;
				start_pos_d  = '0;
				cur_line_d   = LINE_BITS'(1);
				cur_col_d    = LINE_BITS'(1);
				start_line_d = LINE_BITS'(1);
				start_col_d  = LINE_BITS'(1);
				num_d        = '0;
				halted_d     = 1'b0;
			end else if (!halted_q) begin
				case (mode_q)
					MODE_LITERAL: begin
						if (lit_match) begin
							lit_pos_d = 3'(lit_pos_q + 3'd1);
							if (lit_done) mode_d = MODE_IDLE;
						end else begin
							halted_d = 1'b1;
						end
					end
					MODE_STRING: begin
						if (c == CH_QUOTE) mode_d = MODE_IDLE;
					end
					MODE_NUMBER: begin
						if (c_num) begin
							num_d = num_feed(num_q, c, 1'b0);
						end else begin
							mode_d = MODE_IDLE;
							if (fin_halt) halted_d = 1'b1;
						end
					end
					default: ;
				endcase
				if ((mode_q == MODE_IDLE || (mode_q == MODE_NUMBER && !c_num && !fin_halt))
					&& idle_cls != IC_SKIP) begin
					start_pos_d  = byte_pos_q;
					start_line_d = cur_line_q;
					start_col_d  = cur_col_q;
					case (idle_cls)
						IC_LITERAL: begin
							mode_d    = MODE_LITERAL;
							lit_k_d   = idle_lit;
							lit_pos_d = 3'd1;
						end
						IC_STRING: mode_d = MODE_STRING;
						IC_NUMBER: begin
							mode_d = MODE_NUMBER;
							num_d  = num_feed('0, c, 1'b1);
						end
						IC_BAD: halted_d = 1'b1;
						default: ;
					endcase
				end
				if (byte_pos_q != '1) byte_pos_d = byte_pos_q + 1'b1;
				if (c == CH_NEWLINE) begin
					if (cur_line_q != '1) cur_line_d = cur_line_q + 1'b1;
					cur_col_d = LINE_BITS'(1);
				end else if (cur_col_q != '1) begin
					cur_col_d = cur_col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			lit_k_q      <= '0;
			lit_pos_q    <= '0;
			byte_pos_q   <= '0;
			start_pos_q  <= '0;
			cur_line_q   <= LINE_BITS'(1);
			cur_col_q    <= LINE_BITS'(1);
			start_line_q <= LINE_BITS'(1);
			start_col_q  <= LINE_BITS'(1);
			num_q        <= '0;
			halted_q     <= 1'b0;
		end else begin
			mode_q       <= mode_d;
			lit_k_q      <= lit_k_d;
			lit_pos_q    <= lit_pos_d;
			byte_pos_q   <= byte_pos_d;
			start_pos_q  <= start_pos_d;
			cur_line_q   <= cur_line_d;
			cur_col_q    <= cur_col_d;
			start_line_q <= start_line_d;
			start_col_q  <= start_col_d;
			num_q        <= num_d;
			halted_q     <= halted_d;
		end
	end

	assign push_n    = fire ? res_cnt : 2'd0;
	assign pop       = out_valid && out_ready;
	assign wr_ptr_nx = wr_ptr_q + 1'b1;
	assign out_valid = (cnt_q != '0);
	assign out_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) fifo_q[wr_ptr_q] <= res0;
		if (push_n == 2'd2) fifo_q[wr_ptr_nx] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			cnt_q    <= cnt_q + (PTR_W + 1)'(push_n) - (PTR_W + 1)'(pop);
		end
	end

	`JTL_ASSERT_NOW(a_queue_room, fire, (cnt_q + (PTR_W + 1)'(res_cnt)) <= (PTR_W + 1)'(FIFO_DEPTH),
		"result queue overflow")
	`JTL_ASSERT_NOW(a_halt_silent, fire && halted_q, res_cnt == 2'd0,
		"token produced while halted")
	`JTL_ASSERT_NEXT(a_end_clears, fire && is_end, mode_q == MODE_IDLE && !halted_q &&
		byte_pos_q == '0, "end marker did not reset the lexer")
	`JTL_ASSERT_NEXT(a_pos_advance, fire && !is_end && !halted_q,
		byte_pos_q >= $past(byte_pos_q) && byte_pos_q != '0, "byte position did not advance")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the JSON token lexer, driven byte by byte with random flow control.
module testbench;
	import jtl_pkg::*;

	localparam logic       OP_TEXT    = 1'b0;
	localparam logic       OP_END     = 1'b1;
	localparam int         MAX_WAIT   = 17;
	localparam int         RANDOM_REQUESTS = 950;
	localparam logic [31:0] LENGTH_MAX = (32'd1 << OFFSET_BITS) - 32'd1;

	typedef struct packed {
		jtl_in_t    req;
		logic       pinned;
		logic [3:0] kind;
		logic [2:0] code;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 26;

	directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{'{OP_TEXT, "["}, 1'b1, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, "t"}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, "r"}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, "u"}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, "e"}, 1'b1, KIND_TRUE, ERR_NONE},
		'{'{OP_TEXT, 8'h0A}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, 8'h22}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, 8'h00}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, 8'h22}, 1'b1, KIND_STRING, ERR_NONE},
		'{'{OP_TEXT, ":"}, 1'b1, KIND_COLON, ERR_NONE},
		'{'{OP_TEXT, "-"}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, "1"}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, "."}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, "5"}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, "}"}, 1'b1, KIND_RBRACE, ERR_NONE},
		'{'{OP_TEXT, "n"}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, "x"}, 1'b1, KIND_ERR, ERR_LITERAL},
		'{'{OP_TEXT, "{"}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_END, 8'hFF}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, 8'hFF}, 1'b1, KIND_ERR, ERR_NUMBER},
		'{'{OP_END, 8'h00}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, "9"}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_TEXT, " "}, 1'b1, KIND_INT, ERR_NONE},
		'{'{OP_TEXT, "-"}, 1'b0, KIND_LBRACKET, ERR_NONE},
		'{'{OP_END, 8'h00}, 1'b1, KIND_ERR, ERR_NUMBER},
		'{'{OP_END, 8'h00}, 1'b1, KIND_EOF, ERR_NONE}
	};

	string literal_words [3] = '{"true", "false", "null"};
	string number_extremes [8] = '{"2147483647", "-2147483648", "2147483648", "-2147483649",
		"0", "-0", "99999999999", "4294967296"};
	string number_oddities [10] = '{"-", ".", "-.", "1.2.3", "5-3", "--1", "12.", ".5", "1..",
		"-.-"};

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	jtl_in_t   in_data;
	logic      out_valid;
	logic      out_ready;
	jtl_out_t  out_data;

	jtl_out_t pending_tokens [$];
	jtl_out_t step_tokens [$];
	int       mismatches;
	int       sent_requests;
	int       send_gap_max;
	int       stall_max;

	lex_mode_t              lx_mode;
	logic [1:0]             lx_lit_kind;
	logic [2:0]             lx_lit_pos;
	logic [OFFSET_BITS-1:0] lx_pos;
	logic [OFFSET_BITS-1:0] lx_start;
	logic [LINE_BITS-1:0]   lx_line;
	logic [LINE_BITS-1:0]   lx_col;
	logic [LINE_BITS-1:0]   lx_start_line;
	logic [LINE_BITS-1:0]   lx_start_col;
	logic [32:0]            lx_acc;
	num_flags_t             lx_flags;
	logic                   lx_halted;

	json_token_lexer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic is_number_byte(logic [7:0] c);
		return (c == "-") || (c == ".") || ((c >= "0") && (c <= "9"));
	endfunction

	task automatic reset_lexer();
		lx_mode = MODE_IDLE;
		lx_lit_kind = '0;
		lx_lit_pos = '0;
		lx_pos = '0;
		lx_start = '0;
		lx_line = LINE_BITS'(1);
		lx_col = LINE_BITS'(1);
		lx_start_line = LINE_BITS'(1);
		lx_start_col = LINE_BITS'(1);
		lx_acc = '0;
		lx_flags = '0;
		lx_halted = 1'b0;
	endtask

	task automatic mark_start();
		lx_start = lx_pos;
		lx_start_line = lx_line;
		lx_start_col = lx_col;
	endtask

	task automatic emit_token(input logic [3:0] kind, input logic [2:0] code,
			input logic [31:0] value, input logic [31:0] length);
		jtl_out_t t;
		t.token_kind = kind;
		t.error_code = code;
		t.token_int = value;
		t.token_offset = lx_start;
		t.token_length = (length > LENGTH_MAX) ? '1 : length[OFFSET_BITS-1:0];
		t.token_line = lx_start_line;
		t.token_column = lx_start_col;
		t.last_of_run = 1'b0;
		step_tokens.push_back(t);
	endtask

	task automatic feed_number(input logic [7:0] c, input logic first);
		logic [35:0] scaled;
		if (lx_flags.stop) begin
			if (c == CH_DOT) lx_flags.dot = 1'b1;
		end else if (c == CH_MINUS) begin
			if (first) lx_flags.sign = 1'b1;
			else lx_flags.stop = 1'b1;
		end else if (c == CH_DOT) begin
			if (lx_flags.dot) lx_flags.stop = 1'b1;
			else lx_flags.dot = 1'b1;
		end else begin
			lx_flags.digit = 1'b1;
			if (!(lx_flags.dot || lx_flags.ovf)) begin
				scaled = 36'(lx_acc) * 36'd10 + 36'(c - CH_ZERO);
				if (scaled > 36'h080000000) begin
					lx_flags.ovf = 1'b1;
					lx_acc = 33'h080000001;
				end else begin
					lx_acc = scaled[32:0];
				end
			end
		end
	endtask

	task automatic close_number();
		logic [31:0] len;
		logic [31:0] mag;
		len = 32'(lx_pos - lx_start);
		lx_mode = MODE_IDLE;
		if (!lx_flags.digit) begin
			emit_token(KIND_ERR, ERR_NUMBER, 32'd0, len);
			lx_halted = 1'b1;
		end else if (lx_flags.dot) begin
			emit_token(KIND_DEC, ERR_NONE, 32'd0, len);
		end else if (lx_flags.ovf || (!lx_flags.sign && lx_acc > 33'h07FFFFFFF)) begin
			emit_token(KIND_ERR, ERR_OVERFLOW, 32'd0, len);
			lx_halted = 1'b1;
		end else begin
			mag = lx_acc[31:0];
			emit_token(KIND_INT, ERR_NONE, lx_flags.sign ? -mag : mag, len);
		end
	endtask

	task automatic start_token(input logic [7:0] c);
		if (c != CH_SPACE && c != CH_NEWLINE) begin
			mark_start();
			case (c)
				"[": emit_token(KIND_LBRACKET, ERR_NONE, 32'd0, 32'd1);
				"]": emit_token(KIND_RBRACKET, ERR_NONE, 32'd0, 32'd1);
				"{": emit_token(KIND_LBRACE, ERR_NONE, 32'd0, 32'd1);
				"}": emit_token(KIND_RBRACE, ERR_NONE, 32'd0, 32'd1);
				":": emit_token(KIND_COLON, ERR_NONE, 32'd0, 32'd1);
				",": emit_token(KIND_COMMA, ERR_NONE, 32'd0, 32'd1);
				"t", "f", "n": begin
					lx_mode = MODE_LITERAL;
					lx_lit_kind = (c == "t") ? LIT_TRUE : (c == "f") ? LIT_FALSE : LIT_NULL;
					lx_lit_pos = 3'd1;
				end
				CH_QUOTE: lx_mode = MODE_STRING;
				default: begin
					if (is_number_byte(c)) begin
						lx_mode = MODE_NUMBER;
						lx_acc = '0;
						lx_flags = '0;
						feed_number(c, 1'b1);
					end else begin
						emit_token(KIND_ERR, ERR_NUMBER, 32'd0, 32'd0);
						lx_halted = 1'b1;
					end
				end
			endcase
		end
	endtask

	task automatic advance_position(input logic [7:0] c);
		if (lx_pos != '1) lx_pos++;
		if (c == CH_NEWLINE) begin
			if (lx_line != '1) lx_line++;
			lx_col = LINE_BITS'(1);
		end else if (lx_col != '1) begin
			lx_col++;
		end
	endtask

	task automatic predict_tokens(input jtl_in_t req);
		logic [31:0] span;
		logic [7:0]  c;
		string       word;
		jtl_out_t    t;
		step_tokens.delete();
		c = req.data_byte;
		span = 32'(lx_pos - lx_start);
		if (req.opcode == OP_END) begin
			if (!lx_halted) begin
				case (lx_mode)
					MODE_LITERAL: emit_token(KIND_ERR, ERR_LITERAL, 32'd0, span);
					MODE_STRING:
						emit_token(KIND_ERR, ERR_STRING, 32'd0, (span >= 1) ? span - 1 : 32'd0);
					MODE_NUMBER: begin
						close_number();
						if (!lx_halted) begin
							mark_start();
							emit_token(KIND_EOF, ERR_NONE, 32'd0, 32'd0);
						end
					end
					default: begin
						mark_start();
						emit_token(KIND_EOF, ERR_NONE, 32'd0, 32'd0);
					end
				endcase
			end
			reset_lexer();
		end else if (!lx_halted) begin
			if (lx_mode == MODE_LITERAL) begin
				word = literal_words[lx_lit_kind];
				if (lx_lit_pos < word.len() && c == word[lx_lit_pos]) begin
					lx_lit_pos++;
					if (lx_lit_pos >= word.len()) begin
						emit_token(4'(KIND_TRUE + lx_lit_kind), ERR_NONE, 32'd0, word.len());
						lx_mode = MODE_IDLE;
					end
				end else begin
					emit_token(KIND_ERR, ERR_LITERAL, 32'd0, span + 1);
					lx_halted = 1'b1;
				end
			end else if (lx_mode == MODE_STRING) begin
				if (c == CH_QUOTE) begin
					emit_token(KIND_STRING, ERR_NONE, 32'd0, (span >= 1) ? span - 1 : 32'd0);
					lx_mode = MODE_IDLE;
				end
			end else if (lx_mode == MODE_NUMBER) begin
				if (is_number_byte(c)) begin
					feed_number(c, 1'b0);
				end else begin
					close_number();
					if (!lx_halted) start_token(c);
				end
			end else begin
				start_token(c);
			end
			advance_position(c);
		end
		if (step_tokens.size() > 0) begin
			t = step_tokens.pop_back();
			t.last_of_run = 1'b1;
			step_tokens.push_back(t);
		end
		foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
	endtask

	task automatic send_request(input jtl_in_t req);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		predict_tokens(req);
		sent_requests++;
	endtask

	task automatic send_text_byte(input logic [7:0] c);
		send_request(jtl_in_t'{OP_TEXT, c});
	endtask

	task automatic send_word(input string s);
		for (int i = 0; i < s.len(); i++) send_text_byte(s[i]);
	endtask

	task automatic send_number();
		string s;
		case ($urandom_range(0, 3))
			0: begin
				if ($urandom_range(0, 1)) s = $sformatf("%0d", $signed($urandom));
				else s = $sformatf("%s%0d", $urandom_range(0, 1) ? "-" : "", $urandom_range(0, 999));
			end
			1: s = number_extremes[$urandom_range(0, 7)];
			2: s = $sformatf("%s%0d.%0d", $urandom_range(0, 1) ? "-" : "", $urandom_range(0, 99999),
				$urandom_range(0, 999));
			default: s = number_oddities[$urandom_range(0, 9)];
		endcase
		send_word(s);
	endtask

	task automatic send_token();
		int         pick;
		int         cut;
		string      word;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			word = "[]{}:,";
			send_text_byte(word[$urandom_range(0, 5)]);
		end else if (pick < 36) begin
			word = literal_words[$urandom_range(0, 2)];
			cut = $urandom_range(0, 9);
			if (cut == 0) word[$urandom_range(0, word.len() - 1)] = 8'($urandom_range(1, 255));
			else if (cut == 1) word = word.substr(0, $urandom_range(0, word.len() - 2));
			send_word(word);
		end else if (pick < 56) begin
			send_text_byte(CH_QUOTE);
			repeat ($urandom_range(0, 6)) begin
				c = 8'($urandom_range(0, 255));
				if (c == CH_QUOTE) c = "q";
				send_text_byte(c);
			end
			if ($urandom_range(0, 19) != 0) send_text_byte(CH_QUOTE);
		end else if (pick < 82) begin
			send_number();
		end else if (pick < 96) begin
			repeat ($urandom_range(1, 3)) send_text_byte($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
		end else begin
			send_text_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_text();
		repeat ($urandom_range(1, 10)) begin
			send_token();
			if ($urandom_range(0, 1)) send_text_byte($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
		end
		send_request(jtl_in_t'{OP_END, 8'($urandom)});
	endtask

	task automatic wait_for_tokens();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_tokens.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_token(input jtl_out_t got);
		jtl_out_t want;
		if (pending_tokens.size() == 0) begin
			$display("%0t: unexpected token, expected none, actual kind %0d offset %0d", $time,
				got.token_kind, got.token_offset);
			mismatches++;
		end else begin
			want = pending_tokens.pop_front();
			check_field("token_kind", 32'(want.token_kind), 32'(got.token_kind));
			check_field("error_code", 32'(want.error_code), 32'(got.error_code));
			check_field("int_value", want.token_int, got.token_int);
			check_field("token_offset", 32'(want.token_offset), 32'(got.token_offset));
			check_field("token_length", 32'(want.token_length), 32'(got.token_length));
			check_field("token_line", 32'(want.token_line), 32'(got.token_line));
			check_field("token_column", 32'(want.token_column), 32'(got.token_column));
			check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
		end
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			stall = $urandom_range(0, stall_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_token(out_data);
		end
	end

	initial begin
		int text_count;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		mismatches = 0;
		sent_requests = 0;
		send_gap_max = MAX_WAIT;
		stall_max = MAX_WAIT;
		text_count = 0;
		reset_lexer();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_request(directed_rows[i].req);
			if (directed_rows[i].pinned) begin
				if (step_tokens.size() == 0) begin
					$display("%0t: row %0d expected kind %0d, actual no token", $time, i,
						directed_rows[i].kind);
					mismatches++;
				end else if (step_tokens[step_tokens.size() - 1].token_kind != directed_rows[i].kind ||
						step_tokens[step_tokens.size() - 1].error_code != directed_rows[i].code) begin
					$display("%0t: row %0d expected kind %0d code %0d, actual kind %0d code %0d",
						$time, i, directed_rows[i].kind, directed_rows[i].code,
						step_tokens[step_tokens.size() - 1].token_kind,
						step_tokens[step_tokens.size() - 1].error_code);
					mismatches++;
				end
			end
		end
		wait_for_tokens();

		sent_requests = 0;
		while (sent_requests < RANDOM_REQUESTS) begin
			send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
			send_text();
			text_count++;
			if (text_count % 12 == 5) wait_for_tokens();
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_tokens.size() != 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("%0t: timeout with %0d tokens outstanding", $time, pending_tokens.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/jtl_pkg.sv
rtl/json_token_lexer.sv
tb/testbench.sv
